// ===== sv/cfr_pkg.sv =====
package cfr_pkg;

    localparam logic [7:0] SYNC_HI_BYTE = 8'hA5;
    localparam logic [7:0] SYNC_LO_BYTE = 8'h5A;
    localparam logic [7:0] FUNC_BYTE    = 8'h80;

    localparam logic [7:0] DEST_RESET   = 8'h00;
    localparam logic [7:0] SRC_RESET    = 8'hFB;

    localparam int         CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR  = 8'd1;

    // crc-16/xmodem, polynomial 0x1021, four bits per step
    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
        16'h8108, 16'h9129, 16'hA14A, 16'hB16B, 16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
    };

    typedef enum logic [9:0] {
        SLOT_SYNC_HI = 10'b00_0000_0001,
        SLOT_SYNC_LO = 10'b00_0000_0010,
        SLOT_DEST    = 10'b00_0000_0100,
        SLOT_SRC     = 10'b00_0000_1000,
        SLOT_CMD     = 10'b00_0001_0000,
        SLOT_FUNC    = 10'b00_0010_0000,
        SLOT_LEN     = 10'b00_0100_0000,
        SLOT_BODY    = 10'b00_1000_0000,
        SLOT_CRC_HI  = 10'b01_0000_0000,
        SLOT_CRC_LO  = 10'b10_0000_0000
    } t_slot;

    typedef struct packed {
        logic       clear;
        logic       update;
        logic [7:0] data;
    } t_crc_ctrl;

    function automatic logic [15:0] crc_nibble(logic [15:0] crc, logic [3:0] nib);
        logic [3:0] idx;
        begin
            idx = crc[15:12] ^ nib;
            return {crc[11:0], 4'h0} ^ NIB_TABLE[idx];
        end
    endfunction

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
        return crc_nibble(crc_nibble(crc, data[7:4]), data[3:0]);
    endfunction

endpackage

// ===== sv/cfr_if.sv =====
interface cfr_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_code;
    logic [7:0] length_byte;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       frame_start;
    logic       frame_end;

    modport source (
        output valid, command_code, length_byte, body_byte, body_valid, frame_start,
               frame_end,
        input  ready
    );
    modport sink (
        input  valid, command_code, length_byte, body_byte, body_valid, frame_start,
               frame_end,
        output ready
    );
endinterface

interface cfr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

interface cfr_cfg_if
    import cfr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [7:0]           wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== sv/cfr_crc.sv =====
module cfr_crc
    import cfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctrl   i_ctrl,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = 16'h0000;
        end else if (i_ctrl.update) begin
            n_crc = crc_byte(r_crc, i_ctrl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ===== sv/crc16_command_framer_core.sv =====
// command frame builder with running crc-16/xmodem
// i_cmd carries one item per transaction; a start item yields the sync pair,
// destination, source, command, function code 0x80 and length; a body item
// adds one body byte; an end item appends the crc, high byte first, with
// frame_last on the low byte. the crc covers destination through last body byte
// i_cfg writes the destination (index 0) and source (index 1) address
// registers and is always ready; other indexes are ignored
// o_frame carries one frame byte per transaction from an output register
// an item's first byte passes the input register, then the output register
// throughput: one output byte per cycle while o_frame is ready; an item yields
// 1 byte for a body item, up to 10 for start+body+end; an item yielding no byte
// is retired without output. the single output byte lane sets this rate
// when o_frame stalls, the output register and the held item stay put and
// i_cmd deasserts ready until the item's last byte moves into the output register
// reset (synchronous, active low) empties both stages, clears the crc and
// sets destination 0x00 and source 0xFB
module crc16_command_framer_core
    import cfr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfr_cmd_if.sink       i_cmd,
    cfr_cfg_if.sink       i_cfg,
    cfr_frame_if.source   o_frame
);

    logic        r_in_valid;
    logic [7:0]  r_cmd;
    logic [7:0]  r_len;
    logic [7:0]  r_body;
    logic        r_body_valid;
    logic        r_end;
    logic        r_idle_item;
    t_slot       r_slot;
    t_slot       n_slot;
    logic        slot_last;

    logic [7:0]  r_dest;
    logic [7:0]  r_src;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        out_free;
    logic        out_load;
    logic        item_done;
    logic        in_accept;
    logic [7:0]  slot_byte;
    logic [15:0] crc;
    t_crc_ctrl   crc_ctrl;
    t_slot       first_slot;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= DEST_RESET;
            r_src  <= SRC_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == CFG_DEST_ADDR) begin
                r_dest <= i_cfg.wr_data;
            end else if (i_cfg.reg_index == CFG_SRC_ADDR) begin
                r_src <= i_cfg.wr_data;
            end
        end
    end

    // slot sequencing
    always_comb begin
        n_slot    = r_slot;
        slot_last = 1'b0;
        case (r_slot)
            SLOT_SYNC_HI: n_slot = SLOT_SYNC_LO;
            SLOT_SYNC_LO: n_slot = SLOT_DEST;
            SLOT_DEST:    n_slot = SLOT_SRC;
            SLOT_SRC:     n_slot = SLOT_CMD;
            SLOT_CMD:     n_slot = SLOT_FUNC;
            SLOT_FUNC:    n_slot = SLOT_LEN;
            SLOT_LEN: begin
                if (r_body_valid) begin
                    n_slot = SLOT_BODY;
                end else if (r_end) begin
                    n_slot = SLOT_CRC_HI;
                end else begin
                    slot_last = 1'b1;
                end
            end
            SLOT_BODY: begin
                if (r_end) begin
                    n_slot = SLOT_CRC_HI;
                end else begin
                    slot_last = 1'b1;
                end
            end
            SLOT_CRC_HI:  n_slot = SLOT_CRC_LO;
            SLOT_CRC_LO:  slot_last = 1'b1;
            default:      slot_last = 1'b1;
        endcase
    end

    always_comb begin
        if (i_cmd.frame_start) begin
            first_slot = SLOT_SYNC_HI;
        end else if (i_cmd.body_valid) begin
            first_slot = SLOT_BODY;
        end else begin
            first_slot = SLOT_CRC_HI;
        end
    end

    always_comb begin
        case (r_slot)
            SLOT_SYNC_HI: slot_byte = SYNC_HI_BYTE;
            SLOT_SYNC_LO: slot_byte = SYNC_LO_BYTE;
            SLOT_DEST:    slot_byte = r_dest;
            SLOT_SRC:     slot_byte = r_src;
            SLOT_CMD:     slot_byte = r_cmd;
            SLOT_FUNC:    slot_byte = FUNC_BYTE;
            SLOT_LEN:     slot_byte = r_len;
            SLOT_BODY:    slot_byte = r_body;
            SLOT_CRC_HI:  slot_byte = crc[15:8];
            SLOT_CRC_LO:  slot_byte = crc[7:0];
            default:      slot_byte = 8'h00;
        endcase
    end

    assign out_free  = !r_out_valid || o_frame.ready;
    assign out_load  = r_in_valid && !r_idle_item && out_free;
    assign item_done = r_in_valid && (r_idle_item || (out_free && slot_last));
    assign i_cmd.ready = !r_in_valid || item_done;
    assign in_accept = i_cmd.valid && i_cmd.ready;

    // crc covers destination through body
    always_comb begin
        crc_ctrl.clear  = out_load && (r_slot == SLOT_SYNC_HI);
        crc_ctrl.update = out_load && ((r_slot == SLOT_DEST) || (r_slot == SLOT_SRC) ||
                          (r_slot == SLOT_CMD) || (r_slot == SLOT_FUNC) ||
                          (r_slot == SLOT_LEN) || (r_slot == SLOT_BODY));
        crc_ctrl.data   = slot_byte;
    end

    cfr_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_slot     <= SLOT_SYNC_HI;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
            r_slot     <= first_slot;
        end else if (item_done) begin
            r_in_valid <= 1'b0;
        end else if (out_load) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd        <= i_cmd.command_code;
            r_len        <= i_cmd.length_byte;
            r_body       <= i_cmd.body_byte;
            r_body_valid <= i_cmd.body_valid;
            r_end        <= i_cmd.frame_end;
            r_idle_item  <= !(i_cmd.frame_start || i_cmd.body_valid || i_cmd.frame_end);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= slot_byte;
            r_out_last <= (r_slot == SLOT_CRC_LO);
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.frame_last = r_out_last;

    a_slot_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot(r_slot))
        else $error("slot register not one-hot");

    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_slot == SLOT_SYNC_HI) |=> (crc == 16'h0000))
        else $error("crc not cleared by frame start");

    a_crc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_slot == SLOT_CRC_HI || r_slot == SLOT_CRC_LO)) |=> $stable(crc))
        else $error("crc changed while being sent");

    a_last_on_crc_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_slot != SLOT_CRC_LO) |=> !r_out_last)
        else $error("frame_last on a byte other than crc low");

endmodule

// ===== bench/tb_crc16_command_framer_core.sv =====
module tb_crc16_command_framer_core;
    import cfr_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'd2;

    typedef struct packed {
        logic [7:0] command_code;
        logic [7:0] length_byte;
        logic [7:0] body_byte;
        logic       body_valid;
        logic       frame_start;
        logic       frame_end;
    } t_frame_cmd;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_frame_out;

    logic clk;
    logic rst_n;

    cfr_cmd_if   cmd_bus ();
    cfr_cfg_if   cfg_bus ();
    cfr_frame_if frame_bus ();

    crc16_command_framer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus.sink),
        .i_cfg   (cfg_bus.sink),
        .o_frame (frame_bus.source)
    );

    t_frame_cmd  pending_cmds [$];
    t_frame_out  bytes_due [$];

    logic [7:0]  dest_now  = DEST_RESET;
    logic [7:0]  src_now   = SRC_RESET;
    logic [15:0] crc_now   = 16'h0000;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req     = 1'b0;
    int hold_left      = 0;

    int items_accepted = 0;
    int bytes_checked  = 0;
    int frames_closed  = 0;
    int mismatches     = 0;
    int addr_writes    = 0;
    int cycle_count    = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] xmodem_fold(logic [15:0] crc, logic [7:0] data);
        logic [15:0] c;
        int          i;
        c = crc ^ {data, 8'h00};
        for (i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic void emit_byte(logic [7:0] b, logic last, logic covered);
        t_frame_out o;
        o.frame_byte = b;
        o.frame_last = last;
        bytes_due.push_back(o);
        if (covered) begin
            crc_now = xmodem_fold(crc_now, b);
        end
    endfunction

    function automatic void predict_frame_bytes(t_frame_cmd it);
        if (it.frame_start) begin
            crc_now = 16'h0000;
            emit_byte(SYNC_HI_BYTE, 1'b0, 1'b0);
            emit_byte(SYNC_LO_BYTE, 1'b0, 1'b0);
            emit_byte(dest_now, 1'b0, 1'b1);
            emit_byte(src_now, 1'b0, 1'b1);
            emit_byte(it.command_code, 1'b0, 1'b1);
            emit_byte(FUNC_BYTE, 1'b0, 1'b1);
            emit_byte(it.length_byte, 1'b0, 1'b1);
        end
        if (it.body_valid) begin
            emit_byte(it.body_byte, 1'b0, 1'b1);
        end
        if (it.frame_end) begin
            emit_byte(crc_now[15:8], 1'b0, 1'b0);
            emit_byte(crc_now[7:0], 1'b1, 1'b0);
        end
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    // driver
    always @(posedge clk) begin
        t_frame_cmd nxt;
        t_frame_cmd cur;
        if (!rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                cur.command_code = cmd_bus.command_code;
                cur.length_byte  = cmd_bus.length_byte;
                cur.body_byte    = cmd_bus.body_byte;
                cur.body_valid   = cmd_bus.body_valid;
                cur.frame_start  = cmd_bus.frame_start;
                cur.frame_end    = cmd_bus.frame_end;
                predict_frame_bytes(cur);
                items_accepted++;
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    cmd_bus.valid        <= 1'b1;
                    cmd_bus.command_code <= nxt.command_code;
                    cmd_bus.length_byte  <= nxt.length_byte;
                    cmd_bus.body_byte    <= nxt.body_byte;
                    cmd_bus.body_valid   <= nxt.body_valid;
                    cmd_bus.frame_start  <= nxt.frame_start;
                    cmd_bus.frame_end    <= nxt.frame_end;
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        t_frame_out due;
        if (!rst_n) begin
            frame_bus.ready <= 1'b0;
        end else begin
            if (frame_bus.valid && frame_bus.ready) begin
                bytes_checked++;
                if (frame_bus.frame_last) begin
                    frames_closed++;
                end
                if (bytes_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected frame byte %02h last %0b",
                                            frame_bus.frame_byte, frame_bus.frame_last));
                end else begin
                    due = bytes_due.pop_front();
                    if (frame_bus.frame_byte !== due.frame_byte ||
                        frame_bus.frame_last !== due.frame_last) begin
                        note_mismatch($sformatf("byte %0d expected %02h last %0b, got %02h last %0b",
                                                bytes_checked, due.frame_byte, due.frame_last,
                                                frame_bus.frame_byte, frame_bus.frame_last));
                    end
                end
            end
            frame_bus.ready <= (hold_left == 0) && !hold_req &&
                               ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                     bytes_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void queue_cmd(logic [7:0] cmd, logic [7:0] len, logic [7:0] body,
                                      logic bv, logic st, logic en);
        t_frame_cmd it;
        it.command_code = cmd;
        it.length_byte  = len;
        it.body_byte    = body;
        it.body_valid   = bv;
        it.frame_start  = st;
        it.frame_end    = en;
        pending_cmds.push_back(it);
    endfunction

    // one well-formed frame with random content; returns items queued
    function automatic int queue_frame();
        logic [7:0] body [$];
        int         nbody;
        int         n;
        int         i;
        bit         on_start;
        bit         on_end;
        t_frame_cmd it;
        nbody = ($urandom_range(99) < 10) ? $urandom_range(24, 8) : $urandom_range(5, 0);
        if (nbody == 0 && $urandom_range(99) < 40) begin
            body.push_back(8'h00);
        end else begin
            for (i = 0; i < nbody; i++) begin
                body.push_back(8'($urandom));
            end
        end
        on_start = 1'($urandom_range(1));
        on_end   = 1'($urandom_range(1));
        it.command_code = 8'($urandom);
        it.length_byte  = ($urandom_range(99) < 90) ? 8'(nbody) : 8'($urandom);
        it.body_byte    = 8'($urandom);
        it.body_valid   = 1'b0;
        it.frame_start  = 1'b1;
        it.frame_end    = 1'b0;
        if (on_start && body.size() != 0) begin
            it.body_byte  = body.pop_front();
            it.body_valid = 1'b1;
        end
        n = 1;
        while (body.size() != 0) begin
            pending_cmds.push_back(it);
            it.command_code = 8'($urandom);
            it.length_byte  = 8'($urandom);
            it.body_byte    = body.pop_front();
            it.body_valid   = 1'b1;
            it.frame_start  = 1'b0;
            n++;
        end
        if (on_end) begin
            it.frame_end = 1'b1;
            pending_cmds.push_back(it);
        end else begin
            pending_cmds.push_back(it);
            queue_cmd(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
            n++;
        end
        return n;
    endfunction

    function automatic void queue_traffic(int n_items);
        int n;
        n = 0;
        while (n < n_items) begin
            if ($urandom_range(99) < 85) begin
                n += queue_frame();
            end else begin
                queue_cmd(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom));
                n++;
            end
        end
    endfunction

    // sampled away from the rising edge so that driver updates have settled
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_bus.valid || bytes_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= val;
        do @(posedge clk); while (!cfg_bus.ready);
        if (idx == CFG_DEST_ADDR) begin
            dest_now = val;
        end else if (idx == CFG_SRC_ADDR) begin
            src_now = val;
        end
        addr_writes++;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, bit with_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_traffic(ITEMS_PER_PHASE);
        if (with_hold) begin
            @(posedge clk);
            hold_req <= 1'b1;
            @(posedge clk);
            hold_req <= 1'b0;
        end
        wait_idle();
    endtask

    initial begin
        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command_code = 8'h00;
        cmd_bus.length_byte  = 8'h00;
        cmd_bus.body_byte    = 8'h00;
        cmd_bus.body_valid   = 1'b0;
        cmd_bus.frame_start  = 1'b0;
        cmd_bus.frame_end    = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.reg_index    = CFG_DEST_ADDR;
        cfg_bus.wr_data      = 8'h00;
        frame_bus.ready      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed items, reset addresses
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1);
        queue_cmd(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0);
        queue_cmd(8'hAA, 8'h55, 8'hFF, 1'b1, 1'b0, 1'b0);
        queue_cmd(8'h55, 8'hAA, 8'h00, 1'b1, 1'b0, 1'b1);
        queue_cmd(8'h3C, 8'h00, 8'hC3, 1'b0, 1'b1, 1'b1);
        queue_cmd(8'h00, 8'h00, 8'h5A, 1'b1, 1'b0, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_cmd(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
        queue_cmd(8'h12, 8'h02, 8'hA5, 1'b1, 1'b1, 1'b0);
        queue_cmd(8'h34, 8'h01, 8'h80, 1'b0, 1'b1, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h7F, 1'b1, 1'b0, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        queue_cmd(8'h01, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
        queue_cmd(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
        wait_idle();

        run_phase(0, 0, 1'b1);

        write_address_reg(CFG_DEST_ADDR, 8'hFF);
        write_address_reg(CFG_SRC_ADDR, 8'h00);
        write_address_reg(CFG_SPARE_IDX, 8'h5A);
        run_phase(57, 0, 1'b0);

        write_address_reg(CFG_DEST_ADDR, 8'($urandom));
        write_address_reg(CFG_SRC_ADDR, 8'($urandom));
        run_phase(0, 57, 1'b0);

        write_address_reg(CFG_DEST_ADDR, 8'h00);
        write_address_reg(CFG_SRC_ADDR, 8'hFF);
        run_phase(28, 28, 1'b0);

        $display("%0d command items accepted, %0d frame bytes checked, %0d frames closed",
                 items_accepted, bytes_checked, frames_closed);
        $display("%0d address writes, four idling mixes and one long output hold-off",
                 addr_writes);
        if (mismatches == 0 && bytes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
